// File: rtl/core/vafd_pkg.sv
// ----------------------------------------------------------------------------
// vafd_pkg
// Shared types, format codes and the float packing function of the vertex
// attribute format decoder.
// ----------------------------------------------------------------------------
package vafd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] CMD_UB_BGRA = 3'd0;
  localparam logic [2:0] CMD_SNORM16 = 3'd1;
  localparam logic [2:0] CMD_FLOAT   = 3'd2;
  localparam logic [2:0] CMD_RSVD3   = 3'd3;
  localparam logic [2:0] CMD_UB_RGBA = 3'd4;
  localparam logic [2:0] CMD_INT16   = 3'd5;
  localparam logic [2:0] CMD_PACKED  = 3'd6;
  localparam logic [2:0] CMD_RSVD7   = 3'd7;

  localparam logic [31:0] F32_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F32_NEG_ONE = 32'hBF80_0000;

  localparam logic [23:0] MANT_K255   = 24'h80_8081;
  localparam logic [23:0] MANT_K32767 = 24'h80_0100;
  localparam logic [23:0] MANT_ONE    = 24'h80_0000;
  localparam logic [7:0]  ETOP_K255   = 8'd135;
  localparam logic [7:0]  ETOP_K32767 = 8'd128;
  localparam logic [7:0]  ETOP_ONE    = 8'd143;
  localparam logic [7:0]  ETOP_UNIT   = 8'd127;

  localparam logic [10:0] DIV_1023 = 11'd1023;
  localparam logic [9:0]  DIV_511  = 10'd511;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_MUL,
    OP_PK10,
    OP_PK9
  } lane_kind_t;

  typedef enum logic [1:0] {
    KS_255,
    KS_32767,
    KS_ONE
  } kscale_t;

  typedef struct packed {
    lane_kind_t  kind;
    kscale_t     ksel;
    logic        sgn;
    logic        clamp;
    logic [31:0] data;
  } lane_op_t;

  typedef struct packed {
    lane_op_t [3:0] lane;
    logic           supported;
  } item_t;

  typedef struct packed {
    logic        pass;
    logic [31:0] bits;
    logic        sgn;
    logic        clamp;
    logic [47:0] vec;
    logic [7:0]  e_top;
    logic        sticky;
  } lane_mid_t;

  // Leading one of vec lies in bits 47:31 or vec is zero; e_top is the
  // biased exponent for a leading one at bit 47.
  function automatic logic [31:0] pack_f32(input logic sgn, input logic [47:0] vec,
                                           input logic [7:0] e_top, input logic sticky);
    logic [4:0]  lz;
    logic [47:0] sh;
    logic [24:0] mant;
    logic        g;
    logic        s;
    logic [7:0]  e;
    lz = 5'd16;
    for (int i = 0; i < 17; i++) begin
      if (vec[31+i]) lz = 5'(16 - i);
    end
    sh   = vec << lz;
    g    = sh[23];
    s    = (|sh[22:0]) | sticky;
    mant = {1'b0, sh[47:24]} + 25'(g & (s | sh[24]));
    e    = e_top - 8'(lz) + 8'(mant[24]);
    if (vec == '0) return 32'h0;
    return {sgn, e, mant[22:0]};
  endfunction

endpackage

// File: rtl/core/vertex_attribute_format_decode.sv
// ----------------------------------------------------------------------------
// vertex_attribute_format_decode
// Path: queue, back-end mid register and output register, in that order.
// Throughput: one word per cycle; the back end drains the queue every cycle,
// so busy stays low in operation.
// Reset: synchronous active-low rst_n clears the queue and all valid flags.
// ----------------------------------------------------------------------------
module vertex_attribute_format_decode
  import vafd_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_raw_low,
  input  logic [63:0] in_raw_high,
  input  logic [2:0]  in_count,
  input  logic [2:0]  in_cmd,
  output logic        out_valid,
  output logic [31:0] out_comp_x,
  output logic [31:0] out_comp_y,
  output logic [31:0] out_comp_z,
  output logic [31:0] out_comp_w,
  output logic        out_supported
);

  item_t       fr_item, q_item;
  logic        q_full, q_valid;
  logic [31:0] comp [4];

  vafd_front u_front (
    .raw_low  (in_raw_low),
    .raw_high (in_raw_high),
    .count    (in_count),
    .cmd      (in_cmd),
    .item     (fr_item)
  );

  vafd_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (start && !q_full),
    .wr_item  (fr_item),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_item  (q_item)
  );

  vafd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (q_valid),
    .in_item   (q_item),
    .out_vld   (out_valid),
    .comp      (comp),
    .supported (out_supported)
  );

  assign busy       = q_full;
  assign out_comp_x = comp[0];
  assign out_comp_y = comp[1];
  assign out_comp_z = comp[2];
  assign out_comp_w = comp[3];

endmodule

// File: rtl/core/vafd_front.sv
// ----------------------------------------------------------------------------
// vafd_front
// Classifies one element word: picks bytes, halves or fields per component
// and tags each component with the operation the back end performs.
// ----------------------------------------------------------------------------
module vafd_front
  import vafd_pkg::*;
(
  input  logic [63:0] raw_low,
  input  logic [63:0] raw_high,
  input  logic [2:0]  count,
  input  logic [2:0]  cmd,
  output item_t       item
);

  logic [2:0]  n;
  logic        swap;
  logic        present;
  logic [1:0]  bi;
  logic [15:0] h;
  logic [10:0] f11;
  logic [9:0]  f10;

  always_comb begin
    n    = (count > 3'd4) ? 3'd4 : count;
    swap = (cmd == CMD_UB_BGRA) && (n == 3'd4);
    item.supported = 1'b1;
    present = 1'b0;
    bi  = '0;
    h   = '0;
    f11 = '0;
    f10 = '0;
    for (int c = 0; c < 4; c++) begin
      present = 3'(c) < n;
      bi  = swap ? ((c == 3) ? 2'd3 : 2'(2 - c)) : 2'(c);
      h   = raw_low[16*c +: 16];
      f11 = raw_low[11*(c & 1) +: 11];
      f10 = raw_low[31:22];
      item.lane[c].kind  = OP_PASS;
      item.lane[c].ksel  = KS_ONE;
      item.lane[c].sgn   = 1'b0;
      item.lane[c].clamp = 1'b0;
      item.lane[c].data  = (c == 3) ? F32_ONE : 32'h0;
      case (cmd)
        CMD_FLOAT: begin
          if (present) item.lane[c].data = (c < 2) ? raw_low[32*(c & 1) +: 32]
                                                   : raw_high[32*(c & 1) +: 32];
        end
        CMD_UB_BGRA, CMD_UB_RGBA: begin
          if (present) begin
            item.lane[c].kind = OP_MUL;
            item.lane[c].ksel = KS_255;
            item.lane[c].data = {24'h0, raw_low[8*bi +: 8]};
          end
        end
        CMD_SNORM16, CMD_INT16: begin
          if (present) begin
            item.lane[c].kind  = OP_MUL;
            item.lane[c].ksel  = (cmd == CMD_SNORM16) ? KS_32767 : KS_ONE;
            item.lane[c].clamp = (cmd == CMD_SNORM16);
            item.lane[c].sgn   = h[15];
            item.lane[c].data  = {16'h0, h[15] ? 16'(17'h10000 - {1'b0, h}) : h};
          end
        end
        CMD_PACKED: begin
          if (c < 2) begin
            item.lane[c].kind  = OP_PK10;
            item.lane[c].clamp = 1'b1;
            item.lane[c].sgn   = f11[10];
            item.lane[c].data  = {21'h0, f11[10] ? 11'(12'd2048 - {1'b0, f11}) : f11};
          end else if (c == 2) begin
            item.lane[c].kind  = OP_PK9;
            item.lane[c].clamp = 1'b1;
            item.lane[c].sgn   = f10[9];
            item.lane[c].data  = {22'h0, f10[9] ? 10'(11'd1024 - {1'b0, f10}) : f10};
          end
        end
        default: item.supported = 1'b0;
      endcase
    end
  end

endmodule

// File: rtl/core/vafd_queue.sv
// ----------------------------------------------------------------------------
// vafd_queue
// Short word queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module vafd_queue
  import vafd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  output logic  rd_valid,
  output item_t rd_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t           mem [DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            rd_en;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_en    = rd_valid;
  assign rd_item  = mem[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? ((wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = rd_en ? ((rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_item;
  end

endmodule

// File: rtl/core/vafd_back.sv
// ----------------------------------------------------------------------------
// vafd_back
// Four component lanes: pass float words through, or scale or expand to
// fixed point, normalize and round to single precision, clamping at minus one.
// ----------------------------------------------------------------------------
module vafd_back
  import vafd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  item_t       in_item,
  output logic        out_vld,
  output logic [31:0] comp [4],
  output logic        supported
);

  lane_mid_t mid_nxt [4];
  lane_mid_t mid_r   [4];
  logic      mid_vld_r, sup_mid_r;
  logic      out_vld_r, sup_r;
  logic [31:0] comp_r  [4];
  logic [31:0] comp_nxt [4];
  logic [23:0] kmant [4];
  logic [39:0] prod  [4];
  logic        ge    [4];
  logic [9:0]  r10   [4];
  logic [8:0]  r9    [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      case (in_item.lane[c].ksel)
        KS_255:   kmant[c] = MANT_K255;
        KS_32767: kmant[c] = MANT_K32767;
        default:  kmant[c] = MANT_ONE;
      endcase
      prod[c] = in_item.lane[c].data[15:0] * kmant[c];
      ge[c]   = 1'b0;
      r10[c]  = '0;
      r9[c]   = '0;
      mid_nxt[c].pass   = 1'b0;
      mid_nxt[c].bits   = in_item.lane[c].data;
      mid_nxt[c].sgn    = in_item.lane[c].sgn;
      mid_nxt[c].clamp  = in_item.lane[c].clamp;
      mid_nxt[c].vec    = '0;
      mid_nxt[c].e_top  = ETOP_UNIT;
      mid_nxt[c].sticky = 1'b0;
      case (in_item.lane[c].kind)
        OP_MUL: begin
          mid_nxt[c].vec = {prod[c], 8'h0};
          case (in_item.lane[c].ksel)
            KS_255:   mid_nxt[c].e_top = ETOP_K255;
            KS_32767: mid_nxt[c].e_top = ETOP_K32767;
            default:  mid_nxt[c].e_top = ETOP_ONE;
          endcase
        end
        OP_PK10: begin
          ge[c]  = in_item.lane[c].data[10:0] >= DIV_1023;
          r10[c] = 10'(ge[c] ? in_item.lane[c].data[10:0] - DIV_1023
                             : in_item.lane[c].data[10:0]);
          mid_nxt[c].vec    = {ge[c], {4{r10[c]}}, r10[c][9:3]};
          mid_nxt[c].sticky = (r10[c] != '0);
        end
        OP_PK9: begin
          ge[c] = in_item.lane[c].data[9:0] >= DIV_511;
          r9[c] = 9'(ge[c] ? in_item.lane[c].data[9:0] - DIV_511
                           : in_item.lane[c].data[9:0]);
          mid_nxt[c].vec    = {ge[c], {5{r9[c]}}, r9[c][8:7]};
          mid_nxt[c].sticky = (r9[c] != '0);
        end
        default: mid_nxt[c].pass = 1'b1;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      comp_nxt[c] = mid_r[c].pass ? mid_r[c].bits
                  : pack_f32(mid_r[c].sgn, mid_r[c].vec, mid_r[c].e_top, mid_r[c].sticky);
      if (!mid_r[c].pass && mid_r[c].clamp && comp_nxt[c][31] &&
          (comp_nxt[c][30:0] > F32_ONE[30:0])) comp_nxt[c] = F32_NEG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      mid_vld_r <= in_vld;
      out_vld_r <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mid_r     <= mid_nxt;
    sup_mid_r <= in_item.supported;
    comp_r    <= comp_nxt;
    sup_r     <= sup_mid_r;
  end

  assign out_vld   = out_vld_r;
  assign comp      = comp_r;
  assign supported = sup_r;

endmodule

// File: rtl/core/vafd_checker.sv
// ----------------------------------------------------------------------------
// vafd_checker
// Port-level checks on latency and result codes of the format decoder.
// ----------------------------------------------------------------------------
module vafd_checker
  import vafd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_cmd,
  input logic        out_valid,
  input logic [31:0] out_comp_w,
  input logic        out_supported
);

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without word");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ($past(in_cmd, 3) == CMD_RSVD3 || $past(in_cmd, 3) == CMD_RSVD7)
      |-> !out_supported && out_comp_w == F32_ONE)
    else $error("unknown format decoded");

  a_packed_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_cmd, 3) == CMD_PACKED |-> out_supported && out_comp_w == F32_ONE)
    else $error("packed w not one");

endmodule

bind vertex_attribute_format_decode vafd_checker u_vafd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_comp_w    (out_comp_w),
  .out_supported (out_supported)
);
